[src/lsds_pkg.sv]
// Types and constants for the lidar segment detection sorter.
// No dependencies; used by lidar_segment_detection_sorter.
package lsds_pkg;

    localparam logic [28:0] HEADER_ID      = 29'h751;
    localparam logic [28:0] DATA_ID        = 29'h750;
    localparam logic [15:0] RESET_RANGE_CM = 16'd4950;
    localparam logic [8:0]  SEEN_MAX       = 9'd511;
    localparam logic [16:0] AMP_SCALE      = 17'd102400;

    // configuration register indexes
    localparam logic CFG_AMP_OFFSET = 1'b0;
    localparam logic CFG_AMP_SLOPE  = 1'b1;

    typedef struct packed {
        logic [28:0] can_id;
        logic [63:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic [3:0]  segment;
        logic [15:0] kept_range_cm;
        logic [11:0] kept_amplitude;
        logic [15:0] other_range_cm;
        logic [11:0] other_amplitude;
        logic        last_segment;
    } result_t;

    // one segment's entry in the scan memory
    typedef struct packed {
        logic [15:0] kept_range;
        logic [11:0] kept_amp;
        logic [15:0] other_range;
        logic [11:0] other_amp;
    } scan_entry_t;

    localparam scan_entry_t RESET_ENTRY = '{
        kept_range:  RESET_RANGE_CM,
        kept_amp:    12'd0,
        other_range: RESET_RANGE_CM,
        other_amp:   12'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET_RD,
        ST_DET_MUL,
        ST_DET_WR,
        ST_DET_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

[src/lidar_segment_detection_sorter.sv]
// Lidar segment detection sorter: CAN frames in, per-segment scan results out.
// Depends on lsds_pkg (types, constants, sequencer states).
//
// Usage
//   frame channel (frame_valid/frame_ready/frame): one received CAN frame per
//   transfer. Id 0x751 is a header, 0x750 carries two detections, any other
//   id is dropped.
//   result channel (result_valid/result_ready/result): one segment result per
//   transfer, segments in ascending order, last_segment on the final one.
//   cfg port (cfg_we/cfg_index/cfg_wdata): threshold offset and slope; write
//   only while no frame is in flight.
// Sequencing
//   frame_ready is high only while the sequencer is idle. A data frame takes,
//   per detection within the count and segment range, a memory read, a
//   multiply and a write back, then a count check. An emitting frame adds
//   a memory read and an output load per segment; a stall on result_ready
//   holds the sequencer. The scan memory accesses set this order.
// Reset
//   Valid bits for every segment clear at once, so all segments read as
//   4950 cm / zero amplitude; count and registers return to defaults. There
//   is no clearing pass. A header clears the valid bits the same way.
module lidar_segment_detection_sorter #(
    parameter int SEGMENTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    output logic                  frame_ready,
    input  lsds_pkg::frame_t      frame,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lsds_pkg::result_t     result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_wdata
);

    localparam int SEG_W = $clog2(SEGMENTS);

    // scan memory: one entry per segment
    lsds_pkg::scan_entry_t mem [SEGMENTS];

    lsds_pkg::state_t      state_reg, state_next;
    logic                  kidx_reg, kidx_next;
    logic [SEG_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  hdr_emit_reg, hdr_emit_next;
    logic [7:0]            expected_reg, expected_next;
    logic [8:0]            seen_reg, seen_next;
    logic [SEGMENTS-1:0]   valid_reg, valid_next;
    logic [13:0]           offset_reg;
    logic [15:0]           slope_reg;
    lsds_pkg::frame_t      frame_reg;
    logic                  frame_load;

    lsds_pkg::scan_entry_t rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_en;
    logic [SEG_W-1:0]      rd_addr;
    logic                  wr_en;
    lsds_pkg::scan_entry_t wr_entry;

    logic [31:0]           sr_prod_reg;
    logic [28:0]           amp_term_reg;
    logic [30:0]           off_term_reg;

    lsds_pkg::result_t     result_reg, result_d;
    logic                  result_valid_reg, result_valid_next;
    logic                  result_load;

    // current detection fields
    logic [31:0]           det_word;
    logic [15:0]           det_range;
    logic [11:0]           det_amp;
    logic [3:0]            det_seg;
    logic [SEG_W-1:0]      det_addr;
    logic [8:0]            seen_inc;
    lsds_pkg::scan_entry_t cur_entry;
    logic [34:0]           lhs;
    logic                  keep;

    assign det_word  = kidx_reg ? frame_reg.frame_data[63:32] : frame_reg.frame_data[31:0];
    assign det_range = det_word[15:0];
    assign det_amp   = det_word[27:16];
    assign det_seg   = det_word[31:28];
    assign det_addr  = det_seg[SEG_W-1:0];
    assign seen_inc  = (seen_reg < lsds_pkg::SEEN_MAX) ? seen_reg + 9'd1 : seen_reg;

    // entries never written since the last header read as the clear value
    assign cur_entry = rd_vld_reg ? rd_data_reg : lsds_pkg::RESET_ENTRY;

    // A*102400 + 4*S*R > O*102400
    assign lhs  = 35'(amp_term_reg) + {1'b0, sr_prod_reg, 2'b00};
    assign keep = (lhs > 35'(off_term_reg)) && (det_range <= cur_entry.kept_range);

    assign frame_ready  = (state_reg == lsds_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        kidx_next         = kidx_reg;
        emit_idx_next     = emit_idx_reg;
        hdr_emit_next     = hdr_emit_reg;
        expected_next     = expected_reg;
        seen_next         = seen_reg;
        valid_next        = valid_reg;
        frame_load        = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = det_addr;
        wr_en             = 1'b0;
        wr_entry          = cur_entry;
        result_load       = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;
        result_d          = result_reg;

        case (state_reg)
            lsds_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_load = 1'b1;
                    if (frame.can_id == lsds_pkg::HEADER_ID)
                    begin
                        if (seen_reg != 9'd0)
                        begin
                            // flush pending scans before the clear
                            hdr_emit_next = 1'b1;
                            emit_idx_next = '0;
                            state_next    = lsds_pkg::ST_EMIT_RD;
                        end
                        else
                        begin
                            expected_next = frame.frame_data[7:0];
                            valid_next    = '0;
                        end
                    end
                    else if (frame.can_id == lsds_pkg::DATA_ID && expected_reg != 8'd0)
                    begin
                        kidx_next  = 1'b0;
                        state_next = lsds_pkg::ST_DET_RD;
                    end
                end
            end

            lsds_pkg::ST_DET_RD:
            begin
                seen_next = seen_inc;
                if (seen_inc <= {1'b0, expected_reg} && 32'(det_seg) < SEGMENTS)
                begin
                    rd_en      = 1'b1;
                    state_next = lsds_pkg::ST_DET_MUL;
                end
                else if (!kidx_reg)
                    kidx_next = 1'b1;
                else
                    state_next = lsds_pkg::ST_DET_END;
            end

            lsds_pkg::ST_DET_MUL:
            begin
                state_next = lsds_pkg::ST_DET_WR;
            end

            lsds_pkg::ST_DET_WR:
            begin
                wr_en = 1'b1;
                if (keep)
                begin
                    wr_entry.kept_range = det_range;
                    wr_entry.kept_amp   = det_amp;
                end
                else
                begin
                    wr_entry.other_range = det_range;
                    wr_entry.other_amp   = det_amp;
                end
                valid_next[det_addr] = 1'b1;
                if (!kidx_reg)
                begin
                    kidx_next  = 1'b1;
                    state_next = lsds_pkg::ST_DET_RD;
                end
                else
                    state_next = lsds_pkg::ST_DET_END;
            end

            lsds_pkg::ST_DET_END:
            begin
                if (seen_reg == {1'b0, expected_reg})
                begin
                    hdr_emit_next = 1'b0;
                    emit_idx_next = '0;
                    state_next    = lsds_pkg::ST_EMIT_RD;
                end
                else
                    state_next = lsds_pkg::ST_IDLE;
            end

            lsds_pkg::ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = emit_idx_reg;
                state_next = lsds_pkg::ST_EMIT_LD;
            end

            lsds_pkg::ST_EMIT_LD:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_load                = 1'b1;
                    result_valid_next          = 1'b1;
                    result_d.segment           = 4'(emit_idx_reg);
                    result_d.kept_range_cm     = cur_entry.kept_range;
                    result_d.kept_amplitude    = cur_entry.kept_amp;
                    result_d.other_range_cm    = cur_entry.other_range;
                    result_d.other_amplitude   = cur_entry.other_amp;
                    result_d.last_segment      = (emit_idx_reg == SEG_W'(SEGMENTS - 1));
                    if (emit_idx_reg == SEG_W'(SEGMENTS - 1))
                    begin
                        seen_next  = '0;
                        state_next = lsds_pkg::ST_IDLE;
                        if (hdr_emit_reg)
                        begin
                            expected_next = frame_reg.frame_data[7:0];
                            valid_next    = '0;
                        end
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + SEG_W'(1);
                        state_next    = lsds_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = lsds_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lsds_pkg::ST_IDLE;
            kidx_reg         <= 1'b0;
            emit_idx_reg     <= '0;
            hdr_emit_reg     <= 1'b0;
            expected_reg     <= '0;
            seen_reg         <= '0;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kidx_reg         <= kidx_next;
            emit_idx_reg     <= emit_idx_next;
            hdr_emit_reg     <= hdr_emit_next;
            expected_reg     <= expected_next;
            seen_reg         <= seen_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 14'd60;
            slope_reg  <= 16'd1536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsds_pkg::CFG_AMP_OFFSET: offset_reg <= cfg_wdata[13:0];
                lsds_pkg::CFG_AMP_SLOPE:  slope_reg  <= cfg_wdata;
                default:                  slope_reg  <= slope_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (frame_load)
            frame_reg <= frame;
        if (result_load)
            result_reg <= result_d;
        // threshold terms, one register stage before the compare
        sr_prod_reg  <= 32'(slope_reg) * 32'(det_range);
        amp_term_reg <= 29'(det_amp) * 29'(lsds_pkg::AMP_SCALE);
        off_term_reg <= 31'(offset_reg) * 31'(lsds_pkg::AMP_SCALE);
    end

    // scan memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[det_addr] <= wr_entry;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

endmodule

[test/lsds_checker.sv]
// Checker for the lidar segment detection sorter: predicts segment results
// from observed frame and register transfers and compares them in order.
// Depends on lsds_pkg for the channel structs, frame ids and register indexes.
module lsds_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  logic              frame_ready,
    input  lsds_pkg::frame_t  frame,
    input  logic              result_valid,
    input  logic              result_ready,
    input  lsds_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG  = 16;
    localparam int SHOWN = 10;

    // predicted scan contents and detection bookkeeping
    logic [15:0] kept_rng  [NSEG];
    logic [11:0] kept_amp  [NSEG];
    logic [15:0] other_rng [NSEG];
    logic [11:0] other_amp [NSEG];
    logic [7:0]  count_target;
    logic [8:0]  count_seen;
    logic [13:0] amp_offset;
    logic [15:0] amp_slope;

    lsds_pkg::result_t segment_queue[$];
    int                fail_count;

    function automatic string show(input lsds_pkg::result_t r);
        return $sformatf("seg %0d kept %0d/%0d other %0d/%0d last %0b",
                         r.segment, r.kept_range_cm, r.kept_amplitude,
                         r.other_range_cm, r.other_amplitude, r.last_segment);
    endfunction

    task automatic clear_scans();
        int i;
        for (i = 0; i < NSEG; i++)
        begin
            kept_rng[i]  = lsds_pkg::RESET_RANGE_CM;
            kept_amp[i]  = '0;
            other_rng[i] = lsds_pkg::RESET_RANGE_CM;
            other_amp[i] = '0;
        end
    endtask

    task automatic queue_scans();
        int i;
        lsds_pkg::result_t r;
        for (i = 0; i < NSEG; i++)
        begin
            r.segment         = i[3:0];
            r.kept_range_cm   = kept_rng[i];
            r.kept_amplitude  = kept_amp[i];
            r.other_range_cm  = other_rng[i];
            r.other_amplitude = other_amp[i];
            r.last_segment    = (i == NSEG - 1);
            segment_queue.push_back(r);
        end
    endtask

    // threshold: amp*102400 + 4*slope*range > offset*102400, all exact
    task automatic sort_detection(input logic [31:0] word);
        logic [15:0] rng;
        logic [11:0] amp;
        logic [3:0]  seg;
        longint unsigned lhs;
        longint unsigned rhs;
        rng = word[15:0];
        amp = word[27:16];
        seg = word[31:28];
        lhs = 64'(amp) * 64'(lsds_pkg::AMP_SCALE) + 64'd4 * 64'(amp_slope) * 64'(rng);
        rhs = 64'(amp_offset) * 64'(lsds_pkg::AMP_SCALE);
        if (lhs > rhs && rng <= kept_rng[seg])
        begin
            kept_rng[seg] = rng;
            kept_amp[seg] = amp;
        end
        else
        begin
            other_rng[seg] = rng;
            other_amp[seg] = amp;
        end
    endtask

    task automatic apply_frame(input lsds_pkg::frame_t f);
        int k;
        if (f.can_id == lsds_pkg::HEADER_ID)
        begin
            if (count_seen != '0)
                queue_scans();
            count_target = f.frame_data[7:0];
            clear_scans();
            count_seen = '0;
        end
        else if (f.can_id == lsds_pkg::DATA_ID && count_target != '0)
        begin
            for (k = 0; k < 2; k++)
            begin
                if (count_seen != lsds_pkg::SEEN_MAX)
                    count_seen++;
                if (count_seen <= count_target)
                    sort_detection(f.frame_data[32 * k +: 32]);
            end
            if (count_seen == count_target)
            begin
                queue_scans();
                count_seen = '0;
            end
        end
    endtask

    task automatic check_result(input lsds_pkg::result_t got);
        lsds_pkg::result_t want;
        if (segment_queue.size() == 0)
        begin
            fail_count++;
            if (fail_count <= SHOWN)
                $display("%0t: unexpected result: %s", $time, show(got));
        end
        else
        begin
            want = segment_queue.pop_front();
            if (got.segment !== want.segment
                || got.kept_range_cm !== want.kept_range_cm
                || got.kept_amplitude !== want.kept_amplitude
                || got.other_range_cm !== want.other_range_cm
                || got.other_amplitude !== want.other_amplitude
                || got.last_segment !== want.last_segment)
            begin
                fail_count++;
                if (fail_count <= SHOWN)
                    $display("%0t: result differs: expected %s, got %s",
                             $time, show(want), show(got));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_offset   = 14'd60;
            amp_slope    = 16'd1536;
            count_target = '0;
            count_seen   = '0;
            clear_scans();
            segment_queue.delete();
            fail_count   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (cfg_we)
            begin
                if (cfg_index == lsds_pkg::CFG_AMP_OFFSET)
                    amp_offset = cfg_wdata[13:0];
                else
                    amp_slope = cfg_wdata;
            end
            if (frame_valid && frame_ready)
                apply_frame(frame);
            mismatches  <= fail_count;
            outstanding <= segment_queue.size();
        end
    end

endmodule

[test/lidar_segment_detection_sorter_tb.sv]
// Testbench top for the lidar segment detection sorter: drives CAN frames,
// threshold registers and result back-pressure, and gives the verdict.
// Depends on lsds_pkg, lidar_segment_detection_sorter and lsds_checker.
module lidar_segment_detection_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transfer before the run is declared hung; the
    // slowest legal gap is a sender pause plus a settle wait
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles before a register write
    localparam int SETTLE_CYCLES  = 40;

    logic              clk;
    logic              rst_n;
    logic              frame_valid;
    logic              frame_ready;
    lsds_pkg::frame_t  frame;
    logic              result_valid;
    logic              result_ready;
    lsds_pkg::result_t result;
    logic              cfg_we;
    logic              cfg_index;
    logic [15:0]       cfg_wdata;

    int          mismatches;
    int          outstanding;
    int          frames_sent;
    int          idle_cycles;
    int          goal;
    logic        quiet;    // no idling on either side once set

    lidar_segment_detection_sorter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    lsds_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (frame_valid && frame_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: ready stretches of random length broken by stalls of random
    // length; some stretches are long so whole scans drain without a stall.
    initial
    begin
        result_ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            result_ready <= 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30))
                @(posedge clk);
            if (!quiet)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Detection word: range in bits 15..0, amplitude 27..16, segment 31..28.
    function automatic logic [31:0] detection(input logic [3:0] seg,
                                              input logic [15:0] rng,
                                              input logic [11:0] amp);
        return {seg, amp, rng};
    endfunction

    // Segments lean toward a few low numbers so detections collide and the
    // nearest-range rule gets exercised; ranges cluster around the threshold
    // crossover and the 4950 cm reset value.
    function automatic logic [31:0] random_detection();
        logic [3:0]  seg;
        logic [15:0] rng;
        logic [11:0] amp;
        seg = 4'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       rng = 16'($urandom_range(0, 1200));
            1:       rng = 16'($urandom);
            2:       rng = 16'($urandom_range(4940, 4960));
            default: rng = 16'($urandom_range(0, 20000));
        endcase
        amp = 12'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 80));
        return detection(seg, rng, amp);
    endfunction

    // Any id other than header and data; some differ from data by one bit.
    function automatic logic [28:0] stray_id();
        logic [28:0] id;
        do
            id = ($urandom_range(0, 3) == 0)
                 ? (lsds_pkg::DATA_ID ^ (29'd1 << $urandom_range(0, 28)))
                 : 29'($urandom);
        while (id == lsds_pkg::HEADER_ID || id == lsds_pkg::DATA_ID);
        return id;
    endfunction

    // One frame transfer, with an optional idle burst before it. Valid stays
    // high into the next call when no gap is drawn.
    task automatic send_frame(input logic [28:0] id, input logic [63:0] data);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= '{can_id: id, frame_data: data};
        do @(posedge clk); while (!frame_ready);
        if (id == lsds_pkg::HEADER_ID || id == lsds_pkg::DATA_ID)
            frames_sent++;
    endtask

    // Header with the count in byte 0 and junk in the other bytes.
    task automatic send_header(input logic [7:0] count);
        logic [63:0] data;
        data      = {$urandom, $urandom};
        data[7:0] = count;
        send_frame(lsds_pkg::HEADER_ID, data);
    endtask

    task automatic send_data(input logic [31:0] det1, input logic [31:0] det0);
        send_frame(lsds_pkg::DATA_ID, {det1, det0});
    endtask

    // Hold the sender until every predicted result has been transferred,
    // then let the sequencer finish any frame that produced nothing.
    task automatic wait_drained();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers back to back; only called with the block drained.
    task automatic set_thresholds(input logic [15:0] offset, input logic [15:0] slope);
        cfg_we    <= 1'b1;
        cfg_index <= lsds_pkg::CFG_AMP_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_index <= lsds_pkg::CFG_AMP_SLOPE;
        cfg_wdata <= slope;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One scan: a header, then about enough data frames to reach its count.
    // Some scans overshoot or stop early, some counts are odd (never met
    // exactly), and stray ids are sprinkled in between.
    task automatic run_scan();
        int count;
        int nframes;
        int i;
        case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = $urandom_range(17, 40);
            2, 3:    count = 2 * $urandom_range(0, 7) + 1;
            default: count = 2 * $urandom_range(1, 8);
        endcase
        send_header(count[7:0]);
        nframes = (count + 1) / 2;
        if ($urandom_range(0, 7) == 0)
            nframes = nframes + $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0 && nframes > 0)
            nframes = $urandom_range(0, nframes - 1);
        for (i = 0; i < nframes; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_frame(stray_id(), {$urandom, $urandom});
            send_data(random_detection(), random_detection());
        end
    endtask

    task automatic run_scans(input int count);
        goal = frames_sent + count;
        while (frames_sent < goal)
            run_scan();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame       = '0;
        cfg_we      = 1'b0;
        cfg_index   = lsds_pkg::CFG_AMP_OFFSET;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        frames_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset thresholds (offset 60, slope 1536) ---
        // data before any header and stray ids: all dropped
        send_frame(lsds_pkg::DATA_ID, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(29'h0, 64'h0);
        send_frame(29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(29'h1000_0751, {$urandom, $urandom});

        // count 6 over three frames: threshold met exactly goes to the
        // secondary scan, one above is kept; equal range still replaces;
        // past the stored range goes secondary; field extremes on 0 and 15
        send_header(8'd6);
        send_data(detection(4'd0, 16'd0, 12'd61), detection(4'd0, 16'd0, 12'd60));
        send_data(detection(4'd15, 16'hFFFF, 12'd0), detection(4'd0, 16'd0, 12'hFFF));
        send_data(detection(4'd15, 16'd4951, 12'hFFF), detection(4'd15, 16'd4950, 12'd0));

        // count 3: fourth detection dropped, count overshot, no output until
        // the next header emits the scans as they stand
        send_header(8'd3);
        send_data(detection(4'd4, 16'd200, 12'd200), detection(4'd3, 16'd100, 12'd100));
        send_data(detection(4'd6, 16'd300, 12'd300), detection(4'd5, 16'd400, 12'd400));
        send_header(8'd1);
        send_data(detection(4'd8, 16'd10, 12'd10), detection(4'd7, 16'd5000, 12'd2048));

        // count 0: pending scans emitted, following data ignored
        send_header(8'd0);
        send_data(random_detection(), random_detection());

        // count 2 reached twice without a header: scans accumulate across
        // the two emissions; slope term alone exactly at the threshold
        send_header(8'd2);
        send_data(detection(4'd9, 16'd1001, 12'd0), detection(4'd9, 16'd1000, 12'd0));
        send_data(detection(4'd10, 16'd0, 12'd0), detection(4'd9, 16'd999, 12'd100));
        send_header(8'd2);

        // --- random part, several threshold settings ---
        run_scans(15);

        // upper bits of the offset write must be dropped
        wait_drained();
        set_thresholds(16'hFFFF, 16'hFFFF);
        run_scans(25);

        wait_drained();
        set_thresholds(16'h0000, 16'h0000);
        run_scans(20);

        // largest offset with no slope: nothing can pass the threshold
        wait_drained();
        set_thresholds(16'h3FFF, 16'h0000);
        run_scans(15);

        wait_drained();
        set_thresholds(16'($urandom_range(0, 200)), 16'($urandom_range(0, 4000)));

        // odd count of 255 is never met; the detections stay below the count
        // and the next header must still emit the scans
        send_header(8'd255);
        repeat (20) send_data(random_detection(), random_detection());
        send_header(8'($urandom_range(1, 8) * 2));
        run_scans(20);

        // closing stretch at full rate on both channels
        wait_drained();
        quiet = 1'b1;
        set_thresholds(16'd60, 16'd1536);
        run_scans(25);
        send_header(8'd0);

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
